>>> hw/rtl/ufrq_pkg.sv
// ----------------------------------------------------------------------------
// ufrq_pkg
// Shared types, codes and defaults of the UDP fragment retransmit queue.
// ----------------------------------------------------------------------------
package ufrq_pkg;

   localparam int DefQueueDepth   = 64;
   localparam int DefPayloadBytes = 512;

   localparam logic [1:0] FUNC_ENQ_MSG = 2'd0;
   localparam logic [1:0] FUNC_ENQ_HDR = 2'd1;
   localparam logic [1:0] FUNC_ACK     = 2'd2;
   localparam logic [1:0] FUNC_POLL    = 2'd3;

   localparam logic [1:0] STAT_DONE    = 2'd0;
   localparam logic [1:0] STAT_EMIT    = 2'd1;
   localparam logic [1:0] STAT_NOT_DUE = 2'd2;
   localparam logic [1:0] STAT_FULL    = 2'd3;

   localparam logic CSR_RESEND_DELAY  = 1'b0;
   localparam logic CSR_ATTEMPT_LIMIT = 1'b1;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] msg_id;
      logic [7:0]  part_number;
      logic [7:0]  total_parts;
      logic [15:0] msg_length;
      logic        ack_required;
      logic        deflated;
      logic [47:0] peer;
      logic [15:0] buffer_handle;
      logic [31:0] now;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] out_msg_id;
      logic [7:0]  out_part;
      logic [7:0]  out_total;
      logic        out_ack;
      logic        out_deflated;
      logic [47:0] out_peer;
      logic [15:0] out_buffer;
      logic [15:0] payload_offset;
      logic [9:0]  payload_length;
   } rsp_type;

   typedef struct packed {
      logic [15:0] msg_id;
      logic [7:0]  part;
      logic [7:0]  total;
      logic [7:0]  attempts;
      logic        deflated;
      logic        ack;
      logic [47:0] peer;
      logic [15:0] buffer;
      logic [15:0] offset;
      logic [9:0]  length;
      logic [31:0] stamp;
   } entry_type;

   typedef struct packed {
      logic       latch_req;
      logic       set_status;
      logic [1:0] status_code;
      logic       fc_clr;
      logic       fc_step;
      logic       k_clr;
      logic       k_inc;
      logic       rd_search;
      logic       rd_shift;
      logic       rd_head;
      logic       wr_shift;
      logic       wr_frag;
      logic       wr_hdr;
      logic       poll_emit;
      logic       cnt_add;
      logic       cnt_dec;
      logic       load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [1:0] func;
      logic       count_zero;
      logic       count_full;
      logic       fc_done;
      logic       fc_over;
      logic       fc_fit;
      logic       k_end;
      logic       k_last;
      logic       frag_end;
      logic       match;
      logic       due;
   } ctrl_stat_type;

endpackage

>>> hw/rtl/ufrq_datapath.sv
// ----------------------------------------------------------------------------
// ufrq_datapath
// Descriptor memory, circular queue pointers, loop counters and result registers.
// ----------------------------------------------------------------------------
module ufrq_datapath
   import ufrq_pkg::*;
#(
   parameter int QUEUE_DEPTH   = DefQueueDepth,
   parameter int PAYLOAD_BYTES = DefPayloadBytes
) (
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  logic [7:0]    resend_delay,
   input  logic [7:0]    attempt_limit,
   input  ctrl_cmd_type  cmd,
   output ctrl_stat_type stat,
   output rsp_type       rsp_data
);

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int SW = AW + 2;
   localparam int XW = CW + 9;
   localparam logic [SW-1:0] DEPTH_S = SW'(QUEUE_DEPTH);
   localparam logic [XW-1:0] DEPTH_X = XW'(QUEUE_DEPTH);
   localparam logic [16:0]   PB_W    = 17'(PAYLOAD_BYTES);

   entry_type mem [QUEUE_DEPTH];
   entry_type rdata_ff;

   req_type        req_ff;
   rsp_type        res_ff, res_in;
   rsp_type        rsp_ff;
   logic [AW-1:0]  head_ff, head_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  k_ff, k_in;
   logic [8:0]     fc_ff, fc_in;
   logic [16:0]    off_ff, off_in;

   function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
      logic [SW-1:0] t;
      t = (s >= DEPTH_S) ? (s - DEPTH_S) : s;
      return t[AW-1:0];
   endfunction

   logic [SW-1:0] head_s, k_s, count_s;
   logic [AW-1:0] a_hk, a_hk1, a_hc, a_hck, a_h1;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          rd_en, wr_en;
   entry_type     wr_entry, frag_entry, hdr_entry, rq_entry;
   logic [16:0]   rest, plen;
   logic [7:0]    att_new;
   logic          requeue;

   assign head_s  = SW'(head_ff);
   assign k_s     = SW'(k_ff);
   assign count_s = SW'(count_ff);
   assign a_hk    = wrap(head_s + k_s);
   assign a_hk1   = wrap(head_s + k_s + SW'(1));
   assign a_hc    = wrap(head_s + count_s);
   assign a_hck   = wrap(head_s + count_s + k_s);
   assign a_h1    = wrap(head_s + SW'(1));

   assign rest    = {1'b0, req_ff.msg_length} - off_ff;
   assign plen    = (rest > PB_W) ? PB_W : rest;
   assign att_new = (rdata_ff.attempts == 8'hFF) ? 8'hFF : rdata_ff.attempts + 8'd1;
   assign requeue = rdata_ff.ack && (att_new < attempt_limit);

   always_comb begin
      frag_entry          = '0;
      frag_entry.msg_id   = req_ff.msg_id;
      frag_entry.part     = 8'(k_ff) + 8'd1;
      frag_entry.total    = fc_ff[7:0];
      frag_entry.deflated = req_ff.deflated;
      frag_entry.ack      = req_ff.ack_required;
      frag_entry.peer     = req_ff.peer;
      frag_entry.buffer   = req_ff.buffer_handle;
      frag_entry.offset   = off_ff[15:0];
      frag_entry.length   = plen[9:0];

      hdr_entry           = '0;
      hdr_entry.msg_id    = req_ff.msg_id;
      hdr_entry.part      = req_ff.part_number;
      hdr_entry.total     = req_ff.total_parts;
      hdr_entry.deflated  = req_ff.deflated;
      hdr_entry.ack       = req_ff.ack_required;
      hdr_entry.peer      = req_ff.peer;

      rq_entry            = rdata_ff;
      rq_entry.attempts   = att_new;
      rq_entry.stamp      = req_ff.now;
   end

   always_comb begin
      rd_en   = cmd.rd_search | cmd.rd_shift | cmd.rd_head;
      rd_addr = head_ff;
      if (cmd.rd_search) begin
         rd_addr = a_hk;
      end else if (cmd.rd_shift) begin
         rd_addr = a_hk1;
      end
      wr_en    = 1'b0;
      wr_addr  = a_hc;
      wr_entry = hdr_entry;
      if (cmd.wr_shift) begin
         wr_en    = 1'b1;
         wr_addr  = a_hk;
         wr_entry = rdata_ff;
      end else if (cmd.wr_frag) begin
         wr_en    = 1'b1;
         wr_addr  = a_hck;
         wr_entry = frag_entry;
      end else if (cmd.wr_hdr) begin
         wr_en    = 1'b1;
      end else if (cmd.poll_emit && requeue) begin
         wr_en    = 1'b1;
         wr_entry = rq_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_entry;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      k_in     = k_ff;
      fc_in    = fc_ff;
      off_in   = off_ff;
      res_in   = res_ff;
      if (cmd.latch_req) begin
         res_in = '0;
      end
      if (cmd.set_status) begin
         res_in.status = cmd.status_code;
      end
      if (cmd.fc_clr) begin
         fc_in  = '0;
         off_in = '0;
      end
      if (cmd.fc_step) begin
         fc_in  = fc_ff + 9'd1;
         off_in = off_ff + PB_W;
      end
      if (cmd.k_clr) begin
         k_in   = '0;
         off_in = '0;
      end
      if (cmd.k_inc) begin
         k_in = k_ff + CW'(1);
      end
      if (cmd.wr_frag) begin
         k_in   = k_ff + CW'(1);
         off_in = off_ff + PB_W;
      end
      if (cmd.wr_hdr) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.cnt_add) begin
         count_in = count_ff + CW'(fc_ff);
      end
      if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.poll_emit) begin
         head_in = a_h1;
         if (!requeue) begin
            count_in = count_ff - CW'(1);
         end
         res_in.status         = STAT_EMIT;
         res_in.out_msg_id     = rdata_ff.msg_id;
         res_in.out_part       = rdata_ff.part;
         res_in.out_total      = rdata_ff.total;
         res_in.out_ack        = rdata_ff.ack;
         res_in.out_deflated   = rdata_ff.deflated;
         res_in.out_peer       = rdata_ff.peer;
         res_in.out_buffer     = rdata_ff.buffer;
         res_in.payload_offset = rdata_ff.offset;
         res_in.payload_length = rdata_ff.length;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
      k_ff   <= k_in;
      fc_ff  <= fc_in;
      off_ff <= off_in;
      res_ff <= res_in;
      if (cmd.latch_req) begin
         req_ff <= req_data;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= res_ff;
      end
   end

   assign rsp_data = rsp_ff;

   always_comb begin
      stat.func       = req_ff.func;
      stat.count_zero = (count_ff == '0);
      stat.count_full = (count_s == DEPTH_S);
      stat.fc_done    = (off_ff >= {1'b0, req_ff.msg_length}) || fc_ff[8];
      stat.fc_over    = fc_ff[8];
      stat.fc_fit     = XW'(fc_ff) <= (DEPTH_X - XW'(count_ff));
      stat.k_end      = (k_ff == count_ff);
      stat.k_last     = (XW'(k_ff) + XW'(1)) == XW'(count_ff);
      stat.frag_end   = XW'(k_ff) == XW'(fc_ff);
      stat.match      = (rdata_ff.msg_id == req_ff.msg_id) &&
                        (rdata_ff.part == req_ff.part_number);
      stat.due        = ({1'b0, rdata_ff.stamp} + 33'(resend_delay)) < {1'b0, req_ff.now};
   end

endmodule

>>> hw/rtl/ufrq_controller.sv
// ----------------------------------------------------------------------------
// ufrq_controller
// Sequencer that steps the datapath through one request at a time.
// ----------------------------------------------------------------------------
module ufrq_controller
   import ufrq_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  ctrl_stat_type stat,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DECODE, ST_FCOUNT, ST_FCHECK, ST_FWRITE,
      ST_SREAD, ST_SCMP, ST_SHIFT, ST_SHWR, ST_PEVAL, ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (stat.func)
               FUNC_ENQ_MSG: begin
                  cmd.fc_clr = 1'b1;
                  state_in   = ST_FCOUNT;
               end
               FUNC_ENQ_HDR: begin
                  if (stat.count_full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STAT_FULL;
                  end else begin
                     cmd.wr_hdr = 1'b1;
                  end
                  state_in = ST_FINISH;
               end
               FUNC_ACK: begin
                  cmd.k_clr = 1'b1;
                  state_in  = ST_SREAD;
               end
               default: begin
                  if (stat.count_zero) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = STAT_NOT_DUE;
                     state_in        = ST_FINISH;
                  end else begin
                     cmd.rd_head = 1'b1;
                     state_in    = ST_PEVAL;
                  end
               end
            endcase
         end
         ST_FCOUNT: begin
            if (stat.fc_done) begin
               state_in = ST_FCHECK;
            end else begin
               cmd.fc_step = 1'b1;
            end
         end
         ST_FCHECK: begin
            if (stat.fc_over || !stat.fc_fit) begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STAT_FULL;
               state_in        = ST_FINISH;
            end else begin
               cmd.k_clr = 1'b1;
               state_in  = ST_FWRITE;
            end
         end
         ST_FWRITE: begin
            if (stat.frag_end) begin
               cmd.cnt_add = 1'b1;
               state_in    = ST_FINISH;
            end else begin
               cmd.wr_frag = 1'b1;
            end
         end
         ST_SREAD: begin
            if (stat.k_end) begin
               state_in = ST_FINISH;
            end else begin
               cmd.rd_search = 1'b1;
               state_in      = ST_SCMP;
            end
         end
         ST_SCMP: begin
            if (stat.match) begin
               state_in = ST_SHIFT;
            end else begin
               cmd.k_inc = 1'b1;
               state_in  = ST_SREAD;
            end
         end
         ST_SHIFT: begin
            if (stat.k_last) begin
               cmd.cnt_dec = 1'b1;
               state_in    = ST_FINISH;
            end else begin
               cmd.rd_shift = 1'b1;
               state_in     = ST_SHWR;
            end
         end
         ST_SHWR: begin
            cmd.wr_shift = 1'b1;
            cmd.k_inc    = 1'b1;
            state_in     = ST_SHIFT;
         end
         ST_PEVAL: begin
            if (stat.due) begin
               cmd.poll_emit = 1'b1;
            end else begin
               cmd.set_status  = 1'b1;
               cmd.status_code = STAT_NOT_DUE;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hw/rtl/udp_fragment_retransmit_queue_top.sv
// ----------------------------------------------------------------------------
// udp_fragment_retransmit_queue_top
// Ordered queue of outgoing UDP fragment descriptors with timed resend.
// ----------------------------------------------------------------------------
// A request arrives on the req_ channel (valid/ready) and carries one of four
// functions: enqueue a message as fragments, enqueue a header-only entry,
// acknowledge one fragment, or poll the head at the current time. Every
// request gives exactly one result on the rsp_ channel, in request order.
// The block handles one request at a time. A message enqueue first counts
// its fragments, stepping once per fragment, then checks that they fit and
// writes them, again once per fragment. An acknowledge walks the queue entry
// by entry through the descriptor memory, reading and comparing each one,
// and then shifts the rest of the queue down, reading and writing each moved
// entry.
// The result sits in an output register; the next request is taken while it
// waits, and a stalled receiver only holds the block in its final step.
// Reset empties the queue and loads a resend delay of 1 and an attempt limit
// of 3; the descriptor memory needs no clearing pass because only live
// entries are read. The resend delay (address 0) and the attempt limit
// (address 4) are written on the csr_ APB port.
module udp_fragment_retransmit_queue_top
   import ufrq_pkg::*;
#(
   parameter int QUEUE_DEPTH   = DefQueueDepth,
   parameter int PAYLOAD_BYTES = DefPayloadBytes
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   ctrl_cmd_type  cmd;
   ctrl_stat_type stat;
   logic [7:0]    delay_ff, delay_in;
   logic [7:0]    attempts_ff, attempts_in;
   logic          csr_write;

   // The register is chosen by the word address bit; low byte bits are ignored.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      delay_in    = delay_ff;
      attempts_in = attempts_ff;
      if (csr_write) begin
         case (csr_paddr[2])
            CSR_RESEND_DELAY: delay_in    = csr_pwdata[7:0];
            default:          attempts_in = csr_pwdata[7:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff    <= 8'd1;
         attempts_ff <= 8'd3;
      end else begin
         delay_ff    <= delay_in;
         attempts_ff <= attempts_in;
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_ATTEMPT_LIMIT: csr_prdata = {24'd0, attempts_ff};
         default:           csr_prdata = {24'd0, delay_ff};
      endcase
   end

   ufrq_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ufrq_datapath #(
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .PAYLOAD_BYTES (PAYLOAD_BYTES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .req_data      (req_data),
      .resend_delay  (delay_ff),
      .attempt_limit (attempts_ff),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_data      (rsp_data)
   );

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the UDP fragment retransmit queue. A behavioral
// predictor keeps its own copy of the descriptor queue and the two CSRs,
// works out the result of every accepted request, and a checker compares
// each returned result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
   import ufrq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH  = DefQueueDepth;
   localparam int FRAG_B = DefPayloadBytes;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   udp_fragment_retransmit_queue_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // The clock runs at a 20 ns period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Predictor copy of the queue. Index 0 is the head.
   entry_type   q_model[$];
   logic [7:0]  delay_model;
   logic [7:0]  attempts_model;

   // Results still owed by the block, oldest first.
   rsp_type     owed_results[$];
   int          error_count;
   bit          quiet_tail;   // when set, no idling on either side

   // Work out the result of one request and advance the predicted queue.
   function automatic rsp_type predict_request(req_type r);
      rsp_type    res;
      entry_type  e;
      int         frags;
      int         rest;
      logic [7:0] att;
      res = '0;
      res.status = STAT_DONE;
      case (r.func)
         FUNC_ENQ_MSG: begin
            frags = (int'(r.msg_length) + FRAG_B - 1) / FRAG_B;
            if (frags > 255 || frags > DEPTH - q_model.size()) begin
               res.status = STAT_FULL;
            end else begin
               for (int k = 0; k < frags; k++) begin
                  rest       = int'(r.msg_length) - k * FRAG_B;
                  e          = '0;
                  e.msg_id   = r.msg_id;
                  e.part     = 8'(k + 1);
                  e.total    = 8'(frags);
                  e.ack      = r.ack_required;
                  e.deflated = r.deflated;
                  e.peer     = r.peer;
                  e.buffer   = r.buffer_handle;
                  e.offset   = 16'(k * FRAG_B);
                  e.length   = 10'(rest > FRAG_B ? FRAG_B : rest);
                  q_model.insert(q_model.size(), e);
               end
            end
         end
         FUNC_ENQ_HDR: begin
            if (q_model.size() >= DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               e          = '0;
               e.msg_id   = r.msg_id;
               e.part     = r.part_number;
               e.total    = r.total_parts;
               e.ack      = r.ack_required;
               e.deflated = r.deflated;
               e.peer     = r.peer;
               q_model.insert(q_model.size(), e);
            end
         end
         FUNC_ACK: begin
            foreach (q_model[k]) begin
               if (q_model[k].msg_id == r.msg_id && q_model[k].part == r.part_number) begin
                  q_model.delete(k);
                  break;
               end
            end
         end
         default: begin
            if (q_model.size() == 0 ||
                {1'b0, q_model[0].stamp} + 33'(delay_model) >= {1'b0, r.now}) begin
               res.status = STAT_NOT_DUE;
            end else begin
               e = q_model.pop_front();
               res.status         = STAT_EMIT;
               res.out_msg_id     = e.msg_id;
               res.out_part       = e.part;
               res.out_total      = e.total;
               res.out_ack        = e.ack;
               res.out_deflated   = e.deflated;
               res.out_peer       = e.peer;
               res.out_buffer     = e.buffer;
               res.payload_offset = e.offset;
               res.payload_length = e.length;
               att = (e.attempts == 8'hFF) ? e.attempts : e.attempts + 8'd1;
               if (e.ack && att < attempts_model) begin
                  e.attempts = att;
                  e.stamp    = r.now;
                  q_model.insert(q_model.size(), e);
               end
            end
         end
      endcase
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
      error_count++;
   endtask

   // Result checker and receiver-side stall generator.
   initial begin
      int      stall;
      rsp_type want;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid && rsp_ready) begin
            if (owed_results.size() == 0) begin
               report_mismatch("unexpected result status", rsp_data.status, 0);
            end else begin
               want = owed_results.pop_front();
               if (rsp_data.status != want.status)
                  report_mismatch("status", rsp_data.status, want.status);
               if (rsp_data.out_msg_id != want.out_msg_id)
                  report_mismatch("out_msg_id", rsp_data.out_msg_id, want.out_msg_id);
               if (rsp_data.out_part != want.out_part)
                  report_mismatch("out_part", rsp_data.out_part, want.out_part);
               if (rsp_data.out_total != want.out_total)
                  report_mismatch("out_total", rsp_data.out_total, want.out_total);
               if (rsp_data.out_ack != want.out_ack)
                  report_mismatch("out_ack", rsp_data.out_ack, want.out_ack);
               if (rsp_data.out_deflated != want.out_deflated)
                  report_mismatch("out_deflated", rsp_data.out_deflated, want.out_deflated);
               if (rsp_data.out_peer != want.out_peer)
                  report_mismatch("out_peer", rsp_data.out_peer, want.out_peer);
               if (rsp_data.out_buffer != want.out_buffer)
                  report_mismatch("out_buffer", rsp_data.out_buffer, want.out_buffer);
               if (rsp_data.payload_offset != want.payload_offset)
                  report_mismatch("payload_offset", rsp_data.payload_offset,
                                  want.payload_offset);
               if (rsp_data.payload_length != want.payload_length)
                  report_mismatch("payload_length", rsp_data.payload_length,
                                  want.payload_length);
            end
         end
         // Stall the receiver in random bursts, but not near the end.
         if (stall > 0) begin
            stall--;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 8);
         end
         rsp_ready <= (stall == 0);
      end
   end

   // Send one request: an optional idle burst, then hold valid until accepted.
   // Valid stays high after acceptance so that the next request can follow at
   // once; an idle burst or a drain drops it.
   task automatic send_request(req_type r);
      rsp_type prediction;
      if (!quiet_tail && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (!req_ready);
      // The request is taken at this edge, so predict it now.
      prediction = predict_request(r);
      owed_results.insert(owed_results.size(), prediction);
   endtask

   // Wait until every owed result is back, then let the block settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] addr, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr[2] == CSR_ATTEMPT_LIMIT) attempts_model = value[7:0];
      else delay_model = value[7:0];
      @(posedge clock);
   endtask

   // Random request field values; fields not used by a function still toggle.
   function automatic req_type random_request(logic [1:0] fn);
      req_type r;
      r.func          = fn;
      r.msg_id        = 16'($urandom_range(0, 7));
      r.part_number   = 8'($urandom_range(0, 4));
      r.total_parts   = 8'($urandom);
      r.msg_length    = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                    : 16'($urandom_range(0, 2100));
      r.ack_required  = 1'($urandom);
      r.deflated      = 1'($urandom);
      r.peer          = {16'($urandom), 32'($urandom)};
      r.buffer_handle = 16'($urandom);
      r.now           = 32'($urandom);
      if ($urandom_range(0, 1) == 0) r.msg_id = 16'($urandom);
      return r;
   endfunction

   req_type     cur_time_req;
   logic [31:0] clock_secs;   // a slowly moving wall clock for realistic polls

   // Directed corners: extremes, each function, empty, full and unmatched cases.
   task automatic test_directed();
      req_type r;
      r = random_request(FUNC_POLL);
      r.now = 32'hFFFF_FFFF;
      send_request(r);                        // poll on an empty queue
      r = random_request(FUNC_ENQ_MSG);
      r.msg_length = 16'd0;
      send_request(r);                        // empty message adds nothing
      r = random_request(FUNC_ENQ_MSG);
      r.msg_length = 16'hFFFF;
      send_request(r);                        // 128 fragments never fit
      r = random_request(FUNC_ENQ_MSG);
      r.msg_id = 16'hFFFF; r.msg_length = 16'd1025; r.ack_required = 1'b1;
      r.buffer_handle = 16'hFFFF; r.peer = '1; r.deflated = 1'b1;
      send_request(r);                        // three fragments, short tail
      r = random_request(FUNC_ENQ_HDR);
      r.msg_id = 16'h0; r.part_number = 8'hFF; r.total_parts = 8'hFF;
      r.ack_required = 1'b0; r.peer = '0;
      send_request(r);
      r = random_request(FUNC_ACK);
      r.msg_id = 16'h1234; r.part_number = 8'd9;
      send_request(r);                        // acknowledge with no match
      r = random_request(FUNC_ACK);
      r.msg_id = 16'hFFFF; r.part_number = 8'd2;
      send_request(r);                        // remove a middle fragment
      r = random_request(FUNC_POLL);
      r.now = 32'd1;
      send_request(r);                        // 0 + 1 is not earlier than 1
      for (int k = 0; k < 4; k++) begin
         r = random_request(FUNC_POLL);
         r.now = 32'd2 + k;
         send_request(r);
      end
      // Add eight-fragment messages until one no longer fits, then a header and a short message.
      for (int k = 0; k < 8; k++) begin
         r = random_request(FUNC_ENQ_MSG);
         r.msg_length = 16'd4096;
         send_request(r);
      end
      r = random_request(FUNC_ENQ_HDR);
      send_request(r);
      r = random_request(FUNC_ENQ_MSG);
      r.msg_length = 16'd1;
      send_request(r);
      drain_results();
   endtask

   // Random mix with polls that advance the clock so entries come due.
   task automatic test_random_mix(int count);
      req_type r;
      int      pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 9);
         if (pick < 2) r = random_request(FUNC_ENQ_MSG);
         else if (pick < 4) r = random_request(FUNC_ENQ_HDR);
         else if (pick < 6) r = random_request(FUNC_ACK);
         else r = random_request(FUNC_POLL);
         if (r.func == FUNC_ACK && q_model.size() != 0 && $urandom_range(0, 2) != 0) begin
            pick          = $urandom_range(0, q_model.size() - 1);
            r.msg_id      = q_model[pick].msg_id;
            r.part_number = q_model[pick].part;
         end
         if (r.func == FUNC_POLL && $urandom_range(0, 7) != 0) begin
            clock_secs = clock_secs + 32'($urandom_range(0, 300));
            r.now = clock_secs;
         end
         send_request(r);
      end
   endtask

   initial begin
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      error_count = 0;
      quiet_tail  = 1'b0;
      clock_secs  = 32'd0;
      delay_model    = 8'd1;
      attempts_model = 8'd3;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      // Empty the queue by acknowledging everything before the next setting.
      while (q_model.size() != 0) begin
         cur_time_req = random_request(FUNC_ACK);
         cur_time_req.msg_id      = q_model[0].msg_id;
         cur_time_req.part_number = q_model[0].part;
         send_request(cur_time_req);
      end
      drain_results();

      write_csr(3'd0, 32'd0);
      write_csr(3'd4, 32'd255);
      test_random_mix(80);
      drain_results();

      write_csr(3'd0, 32'd255);
      write_csr(3'd4, 32'd1);
      test_random_mix(80);
      drain_results();

      write_csr(3'd0, 32'($urandom_range(0, 60)));
      write_csr(3'd4, 32'($urandom_range(1, 6)));
      test_random_mix(80);
      drain_results();

      write_csr(3'd0, 32'd3);
      write_csr(3'd4, 32'd4);
      quiet_tail = 1'b1;
      test_random_mix(80);
      drain_results();

      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run.
   initial begin
      #20ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
